// ----- hw/rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion helpers used by the checker file slrw_checker.sv
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, switched off while reset is held
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, switched off while reset is held
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/slrw_pkg.sv -----
// ----------------------------------------------------------------------------
// slrw_pkg
// types, command codes and glyph tables for the segment lcd ram writer
// ----------------------------------------------------------------------------
package slrw_pkg;

    localparam int unsigned WORD_W   = 32;
    localparam int unsigned N_COM    = 4;
    localparam int unsigned MASK_W   = 16;
    localparam int unsigned CMD_W    = 2;
    localparam int unsigned POS_W    = 3;
    localparam int unsigned CHAR_W   = 8;
    localparam int unsigned DIGIT_W  = 5;
    localparam int unsigned BIT_IDX_W = 5;

    typedef logic [CMD_W-1:0]     t_cmd;
    typedef logic [POS_W-1:0]     t_pos;
    typedef logic [MASK_W-1:0]    t_mask;
    typedef logic [WORD_W-1:0]    t_word;
    typedef logic [BIT_IDX_W-1:0] t_bit_idx;

    localparam t_cmd CMD_CLEAR = 2'd0;
    localparam t_cmd CMD_CHAR  = 2'd1;
    localparam t_cmd CMD_DIGIT = 2'd2;
    localparam t_cmd CMD_RAW   = 2'd3;

    localparam t_pos POS_LAST = 3'd5;

    localparam logic [CHAR_W-1:0] CHAR_A    = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_Z    = 8'h5a;
    localparam logic [CHAR_W-1:0] CHAR_ZERO = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE = 8'h39;

    // update handed from the encoder to the word store
    typedef struct packed {
        t_word                  keep_mask;
        logic [N_COM-1:0][WORD_W-1:0] set_words;
    } t_update;

    function automatic t_mask letter_glyph(input logic [4:0] idx);
        t_mask g;
        case (idx)
            5'd0:  g = 16'hf00b;
            5'd1:  g = 16'h511e;
            5'd2:  g = 16'h3005;
            5'd3:  g = 16'h511c;
            5'd4:  g = 16'hb005;
            5'd5:  g = 16'hb001;
            5'd6:  g = 16'h300f;
            5'd7:  g = 16'he00b;
            5'd8:  g = 16'h0110;
            5'd9:  g = 16'h400d;
            5'd10: g = 16'ha441;
            5'd11: g = 16'h2005;
            5'd12: g = 16'h6609;
            5'd13: g = 16'h6249;
            5'd14: g = 16'h700d;
            5'd15: g = 16'hf003;
            5'd16: g = 16'h704d;
            5'd17: g = 16'hf043;
            5'd18: g = 16'hb00e;
            5'd19: g = 16'h1110;
            5'd20: g = 16'h600d;
            5'd21: g = 16'h2c01;
            5'd22: g = 16'h6849;
            5'd23: g = 16'h0e40;
            5'd24: g = 16'h0610;
            5'd25: g = 16'h1c04;
            default: g = '0;
        endcase
        return g;
    endfunction

    function automatic t_mask number_glyph(input logic [3:0] idx);
        t_mask g;
        case (idx)
            4'd0: g = 16'h700d;
            4'd1: g = 16'h4008;
            4'd2: g = 16'hd007;
            4'd3: g = 16'h500e;
            4'd4: g = 16'he00a;
            4'd5: g = 16'hb00e;
            4'd6: g = 16'hb00f;
            4'd7: g = 16'h5008;
            4'd8: g = 16'hf00f;
            4'd9: g = 16'hf00e;
            default: g = '0;
        endcase
        return g;
    endfunction

    function automatic t_word clear_mask(input t_pos pos);
        t_word m;
        case (pos)
            3'd0:    m = 32'hcffffffc;
            3'd1:    m = 32'hf3ffff03;
            3'd2:    m = 32'hfcfffcff;
            3'd3:    m = 32'hffcff3ff;
            3'd4:    m = 32'hfff3cfff;
            default: m = 32'hfffc3fff;
        endcase
        return m;
    endfunction

    // destination bit for high pair bit 0/1, low pair bit 0/1
    function automatic t_bit_idx place(input t_pos pos, input logic [1:0] sel);
        logic [3:0][BIT_IDX_W-1:0] row;
        case (pos)
            3'd0:    row = {5'd1,  5'd0,  5'd29, 5'd28};
            3'd1:    row = {5'd7,  5'd2,  5'd27, 5'd26};
            3'd2:    row = {5'd9,  5'd8,  5'd25, 5'd24};
            3'd3:    row = {5'd11, 5'd10, 5'd21, 5'd20};
            3'd4:    row = {5'd13, 5'd12, 5'd19, 5'd18};
            default: row = {5'd15, 5'd14, 5'd16, 5'd17};
        endcase
        return row[sel];
    endfunction

endpackage

// ----- hw/rtl/slrw_encoder.sv -----
// ----------------------------------------------------------------------------
// slrw_encoder
// glyph lookup and bit scatter for one digit command
// ----------------------------------------------------------------------------
module slrw_encoder (
    input  slrw_pkg::t_cmd              i_cmd,
    input  slrw_pkg::t_pos              i_position,
    input  logic [slrw_pkg::CHAR_W-1:0] i_char_code,
    input  logic signed [slrw_pkg::DIGIT_W-1:0] i_digit,
    input  slrw_pkg::t_mask             i_raw_mask,
    output slrw_pkg::t_update           o_update
);

    slrw_pkg::t_pos  pos_c;
    slrw_pkg::t_mask glyph;
    logic [4:0]      char_off;
    logic [3:0]      num_off;

    always_comb begin
        pos_c = (i_position > slrw_pkg::POS_LAST) ? slrw_pkg::POS_LAST : i_position;
        // only the low bits of the offset are needed once the range is known
        char_off = i_char_code[4:0] - slrw_pkg::CHAR_A[4:0];
        num_off  = i_char_code[3:0] - slrw_pkg::CHAR_ZERO[3:0];
        glyph = '0;
        case (i_cmd)
            slrw_pkg::CMD_CHAR: begin
                if (i_char_code >= slrw_pkg::CHAR_A && i_char_code <= slrw_pkg::CHAR_Z) begin
                    glyph = slrw_pkg::letter_glyph(char_off);
                end else if (i_char_code >= slrw_pkg::CHAR_ZERO &&
                             i_char_code <= slrw_pkg::CHAR_NINE) begin
                    glyph = slrw_pkg::number_glyph(num_off);
                end
            end
            slrw_pkg::CMD_DIGIT: begin
                // negative values and 10..15 stay blank
                if (!i_digit[slrw_pkg::DIGIT_W-1] && i_digit[3:0] <= 4'd9) begin
                    glyph = slrw_pkg::number_glyph(i_digit[3:0]);
                end
            end
            slrw_pkg::CMD_RAW: begin
                glyph = i_raw_mask;
            end
            default: begin
                glyph = '0;
            end
        endcase
    end

    // com k takes mask bits 14-2k,15-2k (high pair) and 2k,2k+1 (low pair)
    always_comb begin
        o_update.keep_mask = (i_cmd == slrw_pkg::CMD_CLEAR) ?
                             slrw_pkg::clear_mask(pos_c) : '1;
        for (int k = 0; k < slrw_pkg::N_COM; k++) begin
            o_update.set_words[k] = '0;
            o_update.set_words[k][slrw_pkg::place(pos_c, 2'd0)] = glyph[14 - 2*k];
            o_update.set_words[k][slrw_pkg::place(pos_c, 2'd1)] = glyph[15 - 2*k];
            o_update.set_words[k][slrw_pkg::place(pos_c, 2'd2)] = glyph[2*k];
            o_update.set_words[k][slrw_pkg::place(pos_c, 2'd3)] = glyph[2*k + 1];
        end
    end

endmodule

// ----- hw/rtl/segment_lcd_ram_writer_unit.sv -----
// ----------------------------------------------------------------------------
// segment_lcd_ram_writer_unit
// four-word segment memory image of a six-digit 14-segment lcd
// ----------------------------------------------------------------------------
//  channel   | handshake           | payload
//  ----------+---------------------+------------------------------------------
//  input     | i_valid / o_stall   | i_cmd i_position i_char_code i_digit
//            |                     | i_raw_mask
//  output    | o_valid / i_stall   | o_com0_word .. o_com3_word
//
//  one word per cycle sustained while i_stall stays low; an accepted word goes
//  through the input register, then the encoder and word update into the result
//  register, and o_valid rises as the word is loaded there
//  synchronous active-low reset clears the segment image and both valid flags
//  while the result is stalled the input register still takes one word;
//  o_stall rises only when both registers are full and i_stall is high
// ----------------------------------------------------------------------------
module segment_lcd_ram_writer_unit (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_stall,
    input  slrw_pkg::t_cmd                        i_cmd,
    input  slrw_pkg::t_pos                        i_position,
    input  logic [slrw_pkg::CHAR_W-1:0]           i_char_code,
    input  logic signed [slrw_pkg::DIGIT_W-1:0]   i_digit,
    input  slrw_pkg::t_mask                       i_raw_mask,
    output logic                                  o_valid,
    input  logic                                  i_stall,
    output slrw_pkg::t_word                       o_com0_word,
    output slrw_pkg::t_word                       o_com1_word,
    output slrw_pkg::t_word                       o_com2_word,
    output slrw_pkg::t_word                       o_com3_word
);

    // input register
    logic                                r_in_valid;
    slrw_pkg::t_cmd                      r_cmd;
    slrw_pkg::t_pos                      r_position;
    logic [slrw_pkg::CHAR_W-1:0]         r_char_code;
    logic signed [slrw_pkg::DIGIT_W-1:0] r_digit;
    slrw_pkg::t_mask                     r_raw_mask;

    // segment image, also the result register
    logic                                          r_out_valid;
    logic [slrw_pkg::N_COM-1:0][slrw_pkg::WORD_W-1:0] r_words;
    logic [slrw_pkg::N_COM-1:0][slrw_pkg::WORD_W-1:0] n_words;

    slrw_pkg::t_update update;
    logic              advance;
    logic              in_take;

    // the input register moves on whenever the result register is free
    assign advance = r_in_valid && (!r_out_valid || !i_stall);
    assign o_stall = r_in_valid && r_out_valid && i_stall;
    assign in_take = i_valid && !o_stall;

    slrw_encoder u_enc (
        .i_cmd       (r_cmd),
        .i_position  (r_position),
        .i_char_code (r_char_code),
        .i_digit     (r_digit),
        .i_raw_mask  (r_raw_mask),
        .o_update    (update)
    );

    // clear ands the digit's bits away, glyph commands or them in
    always_comb begin
        for (int k = 0; k < slrw_pkg::N_COM; k++) begin
            n_words[k] = (r_words[k] & update.keep_mask) | update.set_words[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    // payload only, no reset needed
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_cmd       <= i_cmd;
            r_position  <= i_position;
            r_char_code <= i_char_code;
            r_digit     <= i_digit;
            r_raw_mask  <= i_raw_mask;
        end
    end

    // the image itself is state, so it is cleared at reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_words     <= '0;
        end else begin
            if (advance) begin
                r_out_valid <= 1'b1;
                r_words     <= n_words;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid     = r_out_valid;
    assign o_com0_word = r_words[0];
    assign o_com1_word = r_words[1];
    assign o_com2_word = r_words[2];
    assign o_com3_word = r_words[3];

endmodule

// ----- hw/rtl/slrw_checker.sv -----
// ----------------------------------------------------------------------------
// slrw_checker
// port-level checks on the segment lcd ram writer, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module slrw_checker (
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            i_valid,
    input logic            o_stall,
    input logic            o_valid,
    input logic            i_stall,
    input slrw_pkg::t_word o_com0_word,
    input slrw_pkg::t_word o_com1_word,
    input slrw_pkg::t_word o_com2_word,
    input slrw_pkg::t_word o_com3_word
);

    // back-pressure only while a result is held
    `ASSERT_IMP(a_stall_needs_result, i_clk, i_rst_n, o_stall, o_valid, "stall without result")

    // an accepted word must be showing on the output once it has passed the input and result registers
    `ASSERT_IMP(a_accept_to_result, i_clk, i_rst_n, i_valid && !o_stall, ##2 o_valid, "word lost")

    // a stalled result holds its words
    `ASSERT_NXT(a_result_holds, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable({o_com0_word, o_com1_word, o_com2_word, o_com3_word}), "result changed under stall")

endmodule

bind segment_lcd_ram_writer_unit slrw_checker u_slrw_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_valid     (i_valid),
    .o_stall     (o_stall),
    .o_valid     (o_valid),
    .i_stall     (i_stall),
    .o_com0_word (o_com0_word),
    .o_com1_word (o_com1_word),
    .o_com2_word (o_com2_word),
    .o_com3_word (o_com3_word)
);
